@@ src/http_byte_range_parser_core_assert.svh @@
// Assertion macros for the byte range parser checker.
// Needs nothing else; included by the checker file.
`ifndef HTTP_BYTE_RANGE_PARSER_CORE_ASSERT_SVH
`define HTTP_BYTE_RANGE_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define HBRP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbrp assertion failed");

// next-cycle implication
`define HBRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbrp assertion failed");

`endif

@@ src/hbrp_pkg.sv @@
// Shared types, constants and character helpers for the byte range parser.
// No dependencies; compiled first.
package hbrp_pkg;

    localparam int SIZE_W             = 48;
    localparam int CHAR_W             = 8;
    localparam int STATUS_W           = 3;
    localparam int VALUE_BITS_DEFAULT = 48;
    localparam int LIM_W              = 50;
    localparam int PREFIX_POS_W       = 3;

    localparam logic [LIM_W-1:0] ARITH_LIMIT = {1'b1, {(LIM_W-1){1'b0}}};
    localparam logic [PREFIX_POS_W-1:0] PREFIX_LEN = 3'd6;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK             = 3'd0,
        ST_BAD_PREFIX     = 3'd1,
        ST_NO_DASH        = 3'd2,
        ST_START_OOB      = 3'd3,
        ST_START_AFTER_END = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_SKIP   = 3'b001,
        PH_DIGITS = 3'b010,
        PH_DONE   = 3'b100
    } phase_t;

    typedef struct packed {
        logic             neg;
        logic [LIM_W-1:0] lim;
    } reader_val_t;

    typedef struct packed {
        logic prefix_ok;
        logic dash_seen;
        logic suffix_mode;
        logic after_dash_nonempty;
    } parse_flags_t;

    typedef struct packed {
        status_t           status;
        logic              range_ok;
        logic [SIZE_W-1:0] range_start;
        logic [SIZE_W-1:0] range_end;
    } result_t;

    function automatic logic [CHAR_W-1:0] prefix_char(input logic [PREFIX_POS_W-1:0] pos);
        logic [CHAR_W-1:0] c;
        case (pos)
            3'd0:    c = 8'h62; // b
            3'd1:    c = 8'h79; // y
            3'd2:    c = 8'h74; // t
            3'd3:    c = 8'h65; // e
            3'd4:    c = 8'h73; // s
            3'd5:    c = 8'h3D; // =
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

@@ src/hbrp_hdr_if.sv @@
// Header character channel: valid/ready handshake with one character.
// Depends on hbrp_pkg.
interface hbrp_hdr_if;
    import hbrp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

@@ src/hbrp_result_if.sv @@
// Result channel: valid/ready handshake with status and byte range.
// Depends on hbrp_pkg.
interface hbrp_result_if;
    import hbrp_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                range_ok;
    logic [SIZE_W-1:0]   range_start;
    logic [SIZE_W-1:0]   range_end;

    modport source (output valid, output status, output range_ok, output range_start,
                    output range_end, input ready);
    modport sink   (input valid, input status, input range_ok, input range_start,
                    input range_end, output ready);
endinterface

@@ src/hbrp_num_reader.sv @@
// One atoll-style integer reader: whitespace skip, optional sign, saturating digits.
// Depends on hbrp_pkg.
module hbrp_num_reader #(
    parameter int VALUE_BITS = hbrp_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        feed,
    input  logic                        clear,
    input  logic [hbrp_pkg::CHAR_W-1:0] ch,
    output hbrp_pkg::reader_val_t       val
);
    import hbrp_pkg::*;

    localparam int EXT_W = VALUE_BITS + 4;

    phase_t                 phase_reg, phase_next;
    logic                   neg_reg, neg_next;
    logic [VALUE_BITS-1:0]  mag_reg, mag_next;
    logic [EXT_W-1:0]       mag_ext;
    logic [EXT_W-1:0]       acc;
    logic [3:0]             digit;
    logic [VALUE_BITS-1:0]  mag_acc;

    assign digit   = 4'(ch - CH_ZERO);
    assign mag_ext = EXT_W'(mag_reg);
    // mag*10 + d; overflow of VALUE_BITS shows in the top four bits
    assign acc     = (mag_ext << 3) + (mag_ext << 1) + EXT_W'(digit);
    assign mag_acc = (acc[EXT_W-1 -: 4] != 4'd0) ? '1 : acc[VALUE_BITS-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        if (clear)
        begin
            phase_next = PH_SKIP;
            neg_next   = 1'b0;
            mag_next   = '0;
        end
        else if (feed)
        begin
            case (phase_reg)
                PH_SKIP:
                begin
                    if (is_space(ch))
                    begin
                        phase_next = PH_SKIP;
                    end
                    else if ((ch == CH_PLUS) || (ch == CH_DASH))
                    begin
                        neg_next   = (ch == CH_DASH);
                        phase_next = PH_DIGITS;
                    end
                    else if (is_digit(ch))
                    begin
                        mag_next   = mag_acc;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DIGITS:
                begin
                    if (is_digit(ch))
                    begin
                        mag_next = mag_acc;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
        end
    end

    // value limited to 2^49 for range arithmetic
    generate
        if (VALUE_BITS < LIM_W)
        begin : g_narrow
            assign val.lim = LIM_W'(mag_reg);
        end
        else
        begin : g_wide
            assign val.lim = (mag_reg > VALUE_BITS'(ARITH_LIMIT)) ? ARITH_LIMIT
                                                                 : mag_reg[LIM_W-1:0];
        end
    endgenerate

    assign val.neg = neg_reg;

endmodule

@@ src/hbrp_resolve.sv @@
// Resolves suffix, open-ended and closed ranges against the file size.
// Depends on hbrp_pkg; purely combinational.
module hbrp_resolve (
    input  hbrp_pkg::parse_flags_t      flags,
    input  hbrp_pkg::reader_val_t       first,
    input  hbrp_pkg::reader_val_t       second,
    input  logic [hbrp_pkg::SIZE_W-1:0] content_len,
    output hbrp_pkg::result_t           res
);
    import hbrp_pkg::*;

    logic [LIM_W-1:0]  fs_ext;
    logic [LIM_W-1:0]  pos1, pos2;
    logic              negz1, negz2;
    logic [SIZE_W-1:0] fs_m1;
    logic [SIZE_W-1:0] suffix_start;

    // pos: value if non-negative else 0; negz: strictly negative
    assign fs_ext       = LIM_W'(content_len);
    assign pos1         = first.neg ? '0 : first.lim;
    assign pos2         = second.neg ? '0 : second.lim;
    assign negz1        = first.neg && (first.lim != '0);
    assign negz2        = second.neg && (second.lim != '0);
    assign fs_m1        = content_len - SIZE_W'(1);
    assign suffix_start = (pos2 >= fs_ext) ? '0 : (content_len - pos2[SIZE_W-1:0]);

    always_comb
    begin
        res.status      = ST_OK;
        res.range_start = '0;
        res.range_end   = '0;
        if (!flags.prefix_ok)
        begin
            res.status = ST_BAD_PREFIX;
        end
        else if (!flags.dash_seen)
        begin
            res.status = ST_NO_DASH;
        end
        else if (flags.suffix_mode)
        begin
            if ((content_len == '0) || (pos2 == '0))
            begin
                res.status = ST_START_OOB;
            end
            else
            begin
                res.range_start = suffix_start;
                res.range_end   = fs_m1;
            end
        end
        else if (negz1 || (pos1 >= fs_ext))
        begin
            res.status = ST_START_OOB;
        end
        else if (flags.after_dash_nonempty && (negz2 || (pos1 > pos2)))
        begin
            res.status = ST_START_AFTER_END;
        end
        else
        begin
            res.range_start = pos1[SIZE_W-1:0];
            res.range_end   = (flags.after_dash_nonempty && (pos2 < fs_ext))
                              ? pos2[SIZE_W-1:0] : fs_m1;
        end
        res.range_ok = (res.status == ST_OK);
    end

endmodule

@@ src/http_byte_range_parser_core.sv @@
// Top level of the HTTP Range header parser.
// Depends on hbrp_pkg, hbrp_hdr_if, hbrp_result_if, hbrp_num_reader, hbrp_resolve.
//
// Takes one header character per clock; a zero character ends the header and
// produces exactly one result transaction, whose valid rises once the terminator
// has moved from the input register through the per-character state update and
// range resolution into the result register.
// Sustained rate is one character per cycle, set by the parser state update; a
// terminator is held in the input register only while a previous result is still
// waiting in the result register. The user must write the resource size through
// cfg_we/cfg_wdata only while no header is in flight; the block does not enforce it.
module http_byte_range_parser_core #(
    parameter int VALUE_BITS = hbrp_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    hbrp_hdr_if.sink                    hdr,
    hbrp_result_if.source               result,
    input  logic                        cfg_we,
    input  logic [hbrp_pkg::SIZE_W-1:0] cfg_wdata
);
    import hbrp_pkg::*;

    logic [SIZE_W-1:0]       content_len_reg;

    logic                    in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0]       ch_reg;

    logic [PREFIX_POS_W-1:0] prefix_pos_reg, prefix_pos_next;
    logic                    prefix_failed_reg, prefix_failed_next;
    logic                    spec_nonempty_reg, spec_nonempty_next;
    logic                    suffix_mode_reg, suffix_mode_next;
    logic                    dash_seen_reg, dash_seen_next;
    logic                    after_dash_reg, after_dash_next;

    logic                    out_valid_reg, out_valid_next;
    result_t                 result_reg;

    logic                    hdr_fire;
    logic                    out_free;
    logic                    term;
    logic                    advance;
    logic                    step;
    logic                    finish;
    logic                    spec_step;
    parse_flags_t            flags;
    reader_val_t             first_val, second_val;
    result_t                 res;

    assign term      = (ch_reg == CH_NUL);
    assign out_free  = !out_valid_reg || result.ready;
    assign advance   = !term || out_free;
    assign hdr.ready = !in_valid_reg || advance;
    assign hdr_fire  = hdr.valid && hdr.ready;
    assign step      = in_valid_reg && advance;
    assign finish    = step && term;
    assign spec_step = step && !term && !prefix_failed_reg && (prefix_pos_reg == PREFIX_LEN);

    assign in_valid_next = hdr_fire || (in_valid_reg && !advance);

    always_comb
    begin
        prefix_pos_next    = prefix_pos_reg;
        prefix_failed_next = prefix_failed_reg;
        spec_nonempty_next = spec_nonempty_reg;
        suffix_mode_next   = suffix_mode_reg;
        dash_seen_next     = dash_seen_reg;
        after_dash_next    = after_dash_reg;
        if (finish)
        begin
            prefix_pos_next    = '0;
            prefix_failed_next = 1'b0;
            spec_nonempty_next = 1'b0;
            suffix_mode_next   = 1'b0;
            dash_seen_next     = 1'b0;
            after_dash_next    = 1'b0;
        end
        else if (step && !prefix_failed_reg && (prefix_pos_reg != PREFIX_LEN))
        begin
            if (ch_reg == prefix_char(prefix_pos_reg))
            begin
                prefix_pos_next = prefix_pos_reg + PREFIX_POS_W'(1);
            end
            else
            begin
                prefix_failed_next = 1'b1;
            end
        end
        else if (spec_step)
        begin
            if (!spec_nonempty_reg && (ch_reg == CH_DASH))
            begin
                suffix_mode_next = 1'b1;
            end
            spec_nonempty_next = 1'b1;
            if (dash_seen_reg)
            begin
                after_dash_next = 1'b1;
            end
            else if (ch_reg == CH_DASH)
            begin
                dash_seen_next = 1'b1;
            end
        end
    end

    hbrp_num_reader #(
        .VALUE_BITS (VALUE_BITS)
    ) u_first_reader (
        .clk   (clk),
        .rst_n (rst_n),
        .feed  (spec_step),
        .clear (finish),
        .ch    (ch_reg),
        .val   (first_val)
    );

    hbrp_num_reader #(
        .VALUE_BITS (VALUE_BITS)
    ) u_second_reader (
        .clk   (clk),
        .rst_n (rst_n),
        .feed  (spec_step && dash_seen_reg),
        .clear (finish),
        .ch    (ch_reg),
        .val   (second_val)
    );

    assign flags.prefix_ok           = !prefix_failed_reg && (prefix_pos_reg == PREFIX_LEN);
    assign flags.dash_seen           = dash_seen_reg;
    assign flags.suffix_mode         = suffix_mode_reg;
    assign flags.after_dash_nonempty = after_dash_reg;

    hbrp_resolve u_resolve (
        .flags       (flags),
        .first       (first_val),
        .second      (second_val),
        .content_len (content_len_reg),
        .res         (res)
    );

    assign out_valid_next = finish || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            content_len_reg   <= '0;
            in_valid_reg      <= 1'b0;
            prefix_pos_reg    <= '0;
            prefix_failed_reg <= 1'b0;
            spec_nonempty_reg <= 1'b0;
            suffix_mode_reg   <= 1'b0;
            dash_seen_reg     <= 1'b0;
            after_dash_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                content_len_reg <= cfg_wdata;
            end
            in_valid_reg      <= in_valid_next;
            prefix_pos_reg    <= prefix_pos_next;
            prefix_failed_reg <= prefix_failed_next;
            spec_nonempty_reg <= spec_nonempty_next;
            suffix_mode_reg   <= suffix_mode_next;
            dash_seen_reg     <= dash_seen_next;
            after_dash_reg    <= after_dash_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_fire)
        begin
            ch_reg <= hdr.ch;
        end
        if (finish)
        begin
            result_reg <= res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.status      = result_reg.status;
    assign result.range_ok    = result_reg.range_ok;
    assign result.range_start = result_reg.range_start;
    assign result.range_end   = result_reg.range_end;

endmodule

@@ src/hbrp_checker.sv @@
// Port-level checks on the result channel of the byte range parser, bound to the top.
// Depends on hbrp_pkg and http_byte_range_parser_core_assert.svh.
`include "http_byte_range_parser_core_assert.svh"

module hbrp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [hbrp_pkg::STATUS_W-1:0] result_status,
    input logic                          result_range_ok,
    input logic [hbrp_pkg::SIZE_W-1:0]   result_start,
    input logic [hbrp_pkg::SIZE_W-1:0]   result_end
);
    import hbrp_pkg::*;

    `HBRP_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result_status) && $stable(result_start) && $stable(result_end))
    `HBRP_ASSERT_IMPLY(a_range_ok_status, clk, rst_n, result_valid, result_range_ok == (result_status == ST_OK))
    `HBRP_ASSERT_IMPLY(a_no_range_zero, clk, rst_n, result_valid && !result_range_ok, (result_start == '0) && (result_end == '0))
    `HBRP_ASSERT_IMPLY(a_range_order, clk, rst_n, result_valid && result_range_ok, result_start <= result_end)

endmodule

bind http_byte_range_parser_core hbrp_checker u_hbrp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_status   (result.status),
    .result_range_ok (result.range_ok),
    .result_start    (result.range_start),
    .result_end      (result.range_end)
);

@@ tb/http_byte_range_parser_core_tb.sv @@
// Self-checking testbench for http_byte_range_parser_core.
// Drives headers and resource sizes, and checks each result against a range predictor.
// Depends on hbrp_pkg, hbrp_hdr_if, hbrp_result_if and the parser RTL.
`timescale 1ns / 100ps

module http_byte_range_parser_core_tb;
    import hbrp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_CHARS = 140;
    localparam int TOTAL_CHARS = 1500;
    localparam int MIN_RANGES = 60;
    localparam longint unsigned SIZE_MAX = 64'h0000_FFFF_FFFF_FFFF;

    class range_scoreboard;
        logic [SIZE_W-1:0] content_len;
        int                pfx_count;
        bit                pfx_bad;
        bit                spec_seen;
        bit                suffix_req;
        bit                dash_found;
        bit                tail_seen;
        phase_t            lo_phase;
        bit                lo_neg;
        longint unsigned   lo_mag;
        phase_t            hi_phase;
        bit                hi_neg;
        longint unsigned   hi_mag;
        result_t           expected_q[$];
        int                errors;
        int                ranges_checked;
        int                status_seen[5];

        function new();
            content_len = '0;
            errors = 0;
            ranges_checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            pfx_count = 0;
            pfx_bad = 1'b0;
            spec_seen = 1'b0;
            suffix_req = 1'b0;
            dash_found = 1'b0;
            tail_seen = 1'b0;
            lo_phase = PH_SKIP;
            lo_neg = 1'b0;
            lo_mag = 0;
            hi_phase = PH_SKIP;
            hi_neg = 1'b0;
            hi_mag = 0;
        endfunction

        function void set_content_len(logic [SIZE_W-1:0] v);
            content_len = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void scan_number(logic [7:0] c, ref phase_t ph, ref bit neg,
                                  ref longint unsigned mag);
            longint unsigned d;
            if (ph == PH_DONE)
                return;
            if (ph == PH_SKIP) begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                    return;
                if (c == CH_PLUS || c == CH_DASH) begin
                    neg = (c == CH_DASH);
                    ph = PH_DIGITS;
                    return;
                end
            end
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = longint'(c - CH_ZERO);
                if (mag > (SIZE_MAX - d) / 10)
                    mag = SIZE_MAX;
                else
                    mag = mag * 10 + d;
                ph = PH_DIGITS;
            end else begin
                ph = PH_DONE;
            end
        endfunction

        function longint signed_value(bit neg, longint unsigned mag);
            longint v;
            v = (mag > (64'd1 << 49)) ? (longint'(1) << 49) : longint'(mag);
            return neg ? -v : v;
        endfunction

        function result_t resolve_range();
            result_t r;
            longint  fs;
            longint  lo;
            longint  hi;
            longint  second;
            fs = longint'({16'd0, content_len});
            lo = 0;
            hi = 0;
            if (pfx_bad || pfx_count < 6) begin
                r.status = ST_BAD_PREFIX;
            end else if (!dash_found) begin
                r.status = ST_NO_DASH;
            end else begin
                second = signed_value(hi_neg, hi_mag);
                if (suffix_req) begin
                    hi = fs - 1;
                    lo = fs - second;
                    if (lo < 0)
                        lo = 0;
                end else begin
                    lo = signed_value(lo_neg, lo_mag);
                    hi = tail_seen ? second : fs - 1;
                end
                if (lo < 0 || lo >= fs) begin
                    r.status = ST_START_OOB;
                end else begin
                    if (hi >= fs)
                        hi = fs - 1;
                    r.status = (lo > hi) ? ST_START_AFTER_END : ST_OK;
                end
            end
            r.range_ok = (r.status == ST_OK);
            r.range_start = (r.status == ST_OK) ? lo[SIZE_W-1:0] : '0;
            r.range_end = (r.status == ST_OK) ? hi[SIZE_W-1:0] : '0;
            return r;
        endfunction

        function logic [7:0] prefix_text(int pos);
            string p;
            p = "bytes=";
            return p[pos];
        endfunction

        function void take_char(logic [7:0] c);
            if (c == CH_NUL) begin
                expected_q.push_back(resolve_range());
                clear_parse();
                return;
            end
            if (pfx_bad)
                return;
            if (pfx_count < 6) begin
                if (c == prefix_text(pfx_count))
                    pfx_count++;
                else
                    pfx_bad = 1'b1;
                return;
            end
            if (!spec_seen && c == CH_DASH)
                suffix_req = 1'b1;
            spec_seen = 1'b1;
            scan_number(c, lo_phase, lo_neg, lo_mag);
            if (dash_found) begin
                tail_seen = 1'b1;
                scan_number(c, hi_phase, hi_neg, hi_mag);
            end else if (c == CH_DASH) begin
                dash_found = 1'b1;
            end
        endfunction

        function void check_range(result_t got);
            result_t exp;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status %0d start %0d end %0d",
                             got.status, got.range_start, got.range_end);
                return;
            end
            exp = expected_q.pop_front();
            ranges_checked++;
            status_seen[exp.status]++;
            if (got.status !== exp.status || got.range_ok !== exp.range_ok ||
                got.range_start !== exp.range_start || got.range_end !== exp.range_end)
            begin
                errors++;
                if (errors <= 10)
                    $display("range mismatch: expected st %0d ok %0d [%0d,%0d], got st %0d ok %0d [%0d,%0d]",
                             exp.status, exp.range_ok, exp.range_start, exp.range_end,
                             got.status, got.range_ok, got.range_start, got.range_end);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [SIZE_W-1:0] cfg_wdata;

    hbrp_hdr_if    hdr_bus();
    hbrp_result_if res_bus();

    http_byte_range_parser_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr       (hdr_bus),
        .result    (res_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    range_scoreboard sb = new();

    bit              idle_on;
    bit              hold_req;
    int              holds_done;
    int              stall_cycles;
    int              chars_accepted;
    int              sizes_used;
    bit              moved;
    result_t         seen;
    logic [7:0]      text_q[$];
    longint unsigned phase_size[NUM_PHASES];

    string directed_1k[] = '{
        "bytes=0-499", "bytes=500-", "bytes=-200", "bytes=-", "bytes=-2000",
        "bytes=100-50", "bytes=1000-", "bytes=0-99999", "bytes= -5-10", "bytes=5--3",
        "bytes=+5-+9", "bytes= \t12 - 30", "bytes=100", "", "byte", "Bytes=0-1",
        "bytes=99999999999999999999-", "bytes=0-99999999999999999999",
        "bytes=1\377-2", "bytes=1-2x"
    };
    string directed_zero[] = '{"bytes=0-", "bytes=-1"};
    string directed_max[] = '{
        "bytes=0-", "bytes=281474976710654-281474976710655", "bytes=-281474976710655"
    };

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // transaction monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n) begin
            moved = 1'b0;
            if (res_bus.valid && res_bus.ready) begin
                seen.status = status_t'(res_bus.status);
                seen.range_ok = res_bus.range_ok;
                seen.range_start = res_bus.range_start;
                seen.range_end = res_bus.range_end;
                sb.check_range(seen);
                moved = 1'b1;
            end
            if (hdr_bus.valid && hdr_bus.ready) begin
                sb.take_char(hdr_bus.ch);
                chars_accepted++;
                moved = 1'b1;
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", stall_cycles);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // result receiver: random backpressure plus one long hold-off on request
    initial begin
        res_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req) begin
                res_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                holds_done++;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end else begin
                res_bus.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_char(input logic [7:0] c);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            hdr_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        hdr_bus.valid <= 1'b1;
        hdr_bus.ch <= c;
        do @(posedge clk); while (!hdr_bus.ready);
    endtask

    task automatic send_queue();
        foreach (text_q[i]) send_char(text_q[i]);
        send_char(CH_NUL);
    endtask

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    task automatic send_text(input string s);
        text_q.delete();
        push_str(s);
        send_queue();
    endtask

    task automatic drain();
        hdr_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_content_len(input logic [SIZE_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_content_len(v);
        sizes_used++;
    endtask

    function automatic longint unsigned rand48();
        return {$urandom, $urandom} & SIZE_MAX;
    endfunction

    function automatic void push_ws();
        logic [7:0] ws[6] = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32};
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 2)) text_q.push_back(ws[$urandom_range(0, 5)]);
    endfunction

    function automatic void push_sign();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            text_q.push_back(CH_PLUS);
        else if (r == 1)
            text_q.push_back(CH_DASH);
    endfunction

    function automatic void push_num(longint unsigned fs);
        longint unsigned v;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = (fs == 0) ? 0 : fs - 1;
            2: v = fs;
            3: v = fs + 1;
            4, 5, 6: v = rand48() % (fs + 1);
            7: v = rand48();
            8: v = 0;
            default: v = $urandom_range(0, 20);
        endcase
        if ($urandom_range(0, 9) == 8) begin
            repeat ($urandom_range(15, 22))
                text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end else begin
            push_str($sformatf("%0d", v));
        end
    endfunction

    function automatic void push_junk(int max_len);
        string alpha;
        alpha = "0123456789+- \t";
        repeat ($urandom_range(0, max_len)) begin
            if ($urandom_range(0, 1) == 0)
                text_q.push_back(alpha[$urandom_range(0, alpha.len() - 1)]);
            else
                text_q.push_back(8'($urandom_range(1, 255)));
        end
    endfunction

    function automatic void make_header(longint unsigned fs);
        int kind;
        text_q.delete();
        kind = $urandom_range(0, 19);
        if (kind < 14) begin
            push_str("bytes=");
            case ($urandom_range(0, 2))
                0: begin
                    push_ws(); push_sign(); push_num(fs); push_ws();
                    text_q.push_back(CH_DASH);
                    push_ws(); push_sign(); push_num(fs); push_ws();
                end
                1: begin
                    push_ws(); push_sign(); push_num(fs);
                    text_q.push_back(CH_DASH);
                end
                default: begin
                    text_q.push_back(CH_DASH);
                    if ($urandom_range(0, 7) != 0)
                        push_num(fs);
                end
            endcase
            if ($urandom_range(0, 7) == 0)
                push_junk(4);
        end else if (kind < 16) begin
            push_str("bytes=");
            if ($urandom_range(0, 1) == 0)
                text_q[$urandom_range(0, 5)] = 8'($urandom_range(1, 255));
            else
                while (text_q.size() > $urandom_range(0, 5)) void'(text_q.pop_back());
            push_junk(6);
        end else if (kind < 18) begin
            push_str("bytes=");
            push_junk(8);
        end else begin
            repeat ($urandom_range(0, 10)) text_q.push_back(8'($urandom_range(1, 255)));
        end
    endfunction

    initial begin
        int phase_chars;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        hdr_bus.valid <= 1'b0;
        hdr_bus.ch <= CH_NUL;
        idle_on = 1'b1;
        hold_req = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_content_len(48'd1000);
        foreach (directed_1k[i]) send_text(directed_1k[i]);
        drain();
        write_content_len(48'd0);
        foreach (directed_zero[i]) send_text(directed_zero[i]);
        drain();
        write_content_len(SIZE_MAX[SIZE_W-1:0]);
        foreach (directed_max[i]) send_text(directed_max[i]);

        phase_size[0] = 1;
        phase_size[1] = SIZE_MAX;
        phase_size[2] = 1000;
        phase_size[3] = 0;
        phase_size[4] = $urandom_range(2, 5000);
        phase_size[5] = rand48();
        phase_size[6] = $urandom_range(1, 100);
        phase_size[7] = rand48() >> $urandom_range(0, 40);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            write_content_len(phase_size[p][SIZE_W-1:0]);
            if (p == 2)
                hold_req = 1'b1;
            if (p == NUM_PHASES - 1)
                idle_on = 1'b0;
            phase_chars = chars_accepted;
            while (chars_accepted - phase_chars < PHASE_CHARS ||
                   (p == NUM_PHASES - 1 &&
                    (chars_accepted < TOTAL_CHARS ||
                     sb.ranges_checked + sb.pending() < MIN_RANGES))) begin
                make_header(phase_size[p]);
                send_queue();
            end
        end
        drain();
        repeat (8) @(posedge clk);

        sb.errors += sb.pending();
        $display("run: %0d characters, %0d results checked, %0d file sizes, %0d long hold-offs",
                 chars_accepted, sb.ranges_checked, sizes_used, holds_done);
        $display("statuses ok %0d, bad prefix %0d, no dash %0d, start oob %0d, start > end %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_BAD_PREFIX],
                 sb.status_seen[ST_NO_DASH], sb.status_seen[ST_START_OOB],
                 sb.status_seen[ST_START_AFTER_END]);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
